// ===== rtl/dht_pkg.sv =====
// Shared types, codes and constants for the double hashing table unit.
`default_nettype none

package dht_pkg;

  localparam int KEY_W        = 31;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int SLOT_OUT_W   = 4;
  localparam int TABLE_SIZE_DEF   = 16;
  localparam int STEP_MODULUS_DEF = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } dht_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
  } dht_result_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic hash_en;
    logic reduce_en;
    logic probe_en;
    logic finish;
  } dht_ctl_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic hash_last;
    logic reduce_last;
    logic probe_hit;
    logic probe_miss;
  } dht_sts_t;

endpackage

`default_nettype wire

// ===== rtl/double_hash_table_unit.sv =====
// Top level of the double hashing open-addressing table.
//
//   port group          direction  transfer
//   start/busy/cmd_i    in         start high while busy low
//   done_o/result_o     out        done_o high for one cycle, no back-pressure
//
// Zero key or unused mode: the check state finishes without hashing or probing.
// Otherwise: check, hash, step-reduce and probe states in turn; the probe walk reads
// at most TABLE_SIZE slots, one at a time, through the single read port of the slot memory.
// After reset the unit clears every slot of the slot memory, busy high.
// busy stays high from the transfer until the result cycle; the receiver cannot stall.
`default_nettype none

module double_hash_table_unit
  import dht_pkg::*;
#(
  parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = STEP_MODULUS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire dht_cmd_t cmd_i,
  output logic          done_o,
  output dht_result_t   result_o
);

  dht_ctl_t ctl;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctl_o   (ctl),
    .sts_i   (sts)
  );

  dht_datapath #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/dht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dht_datapath.sv =====
// Datapath: hash remainders, step reduction, probe walk, slot memory and result register.
`default_nettype none

module dht_datapath
  import dht_pkg::*;
#(
  parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = STEP_MODULUS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dht_cmd_t    cmd_i,
  input  wire dht_ctl_t    ctl_i,
  output dht_sts_t         sts_o,
  output dht_result_t      result_o
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int MR_W    = $clog2(STEP_MODULUS);
  localparam int SW      = $clog2(STEP_MODULUS + 1);
  localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam int EXT_W   = IDX_W + SLOT_OUT_W;
  localparam int PROD_W  = 2 * KEY_W + 1;
  localparam int SPROD_W = 2 * SW + 1;
  localparam int SH_T    = KEY_W + $clog2(TABLE_SIZE);
  localparam int SH_M    = KEY_W + $clog2(STEP_MODULUS);
  localparam int SH_S    = SW + $clog2(TABLE_SIZE);
  localparam logic [KEY_W:0] RCP_T =
    (KEY_W + 1)'((64'd1 << SH_T) / 64'(TABLE_SIZE) + 64'd1);
  localparam logic [KEY_W:0] RCP_M =
    (KEY_W + 1)'((64'd1 << SH_M) / 64'(STEP_MODULUS) + 64'd1);
  localparam logic [SW:0] RCP_S =
    (SW + 1)'((64'd1 << SH_S) / 64'(TABLE_SIZE) + 64'd1);
  localparam logic [IDX_W:0] T_EXT = (IDX_W + 1)'(TABLE_SIZE);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_pos_q;
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  quo_t_q;
  logic [KEY_W-1:0]  quo_m_q;
  logic [SW-1:0]     step_q;
  logic [SW-1:0]     quo_s_q;
  logic [IDX_W-1:0]  step_rem_q;
  logic [IDX_W-1:0]  pos_q;
  dht_result_t       result_q;

  logic [PROD_W-1:0]  prod_t;
  logic [PROD_W-1:0]  prod_m;
  logic [SPROD_W-1:0] prod_s;
  logic [IDX_W-1:0]   rt;
  logic [MR_W-1:0]    rm;
  logic [IDX_W-1:0]   rs;
  logic [IDX_W:0]     ps;
  logic [SW-1:0]      step_new;
  logic               issue;
  logic               hit;
  logic [KEY_W-1:0]   target;
  logic [KEY_W-1:0]   rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic [EXT_W-1:0]   pos_ext;
  dht_result_t        result_d;

  assign prod_t = PROD_W'(key_q) * PROD_W'(RCP_T);
  assign prod_m = PROD_W'(key_q) * PROD_W'(RCP_M);
  assign prod_s = SPROD_W'(step_q) * SPROD_W'(RCP_S);

  assign rt = key_q[IDX_W-1:0] - quo_t_q[IDX_W-1:0] * IDX_W'(TABLE_SIZE);
  assign rm = key_q[MR_W-1:0] - quo_m_q[MR_W-1:0] * MR_W'(STEP_MODULUS);
  assign rs = IDX_W'(step_q) - IDX_W'(quo_s_q) * IDX_W'(TABLE_SIZE);

  assign step_new = SW'(STEP_MODULUS) - SW'(rm);

  always_comb begin
    ps = {1'b0, pos_q} + {1'b0, step_rem_q};
    if (ps >= T_EXT) begin
      ps = ps - T_EXT;
    end
  end

  assign issue  = ctl_i.probe_en && (cnt_q < CNT_W'(TABLE_SIZE));
  assign target = (mode_q == MODE_INSERT) ? '0 : key_q;
  assign hit    = rd_valid_q && (rd_data == target);

  assign sts_o.clear_last  = (cnt_q == CNT_W'(TABLE_SIZE - 1));
  assign sts_o.skip        = (key_q == '0) ||
                             ((mode_q != MODE_INSERT) && (mode_q != MODE_SEARCH) &&
                              (mode_q != MODE_DELETE));
  assign sts_o.hash_last   = (cnt_q == CNT_W'(1));
  assign sts_o.reduce_last = (cnt_q == CNT_W'(1));
  assign sts_o.probe_hit   = hit;
  assign sts_o.probe_miss  = (cnt_q == CNT_W'(TABLE_SIZE));

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.load) begin
      cnt_d = '0;
    end else if (ctl_i.clear_en || ctl_i.hash_en || ctl_i.reduce_en) begin
      if ((ctl_i.hash_en && sts_o.hash_last) || (ctl_i.reduce_en && sts_o.reduce_last)) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= cmd_i.mode;
      key_q  <= cmd_i.key;
    end else if (ctl_i.hash_en) begin
      if (sts_o.hash_last) begin
        pos_q  <= rt;
        step_q <= step_new;
      end else begin
        quo_t_q <= KEY_W'(prod_t >> SH_T);
        quo_m_q <= KEY_W'(prod_m >> SH_M);
      end
    end else if (ctl_i.reduce_en) begin
      if (sts_o.reduce_last) begin
        step_rem_q <= rs;
      end else begin
        quo_s_q <= SW'(prod_s >> SH_S);
      end
    end else if (issue) begin
      pos_q    <= ps[IDX_W-1:0];
      rd_pos_q <= pos_q;
    end
    if (ctl_i.finish) begin
      result_q <= result_d;
    end
  end

  assign pos_ext = EXT_W'(rd_pos_q);

  always_comb begin
    result_d.slot_index = '0;
    if (key_q == '0) begin
      result_d.status = ST_ZERO_KEY;
    end else if (hit) begin
      result_d.status     = ST_OK;
      result_d.slot_index = pos_ext[SLOT_OUT_W-1:0];
    end else if (mode_q == MODE_INSERT) begin
      result_d.status = ST_FULL;
    end else begin
      result_d.status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_pos_q;
    mem_wdata = '0;
    if (ctl_i.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[IDX_W-1:0];
    end else if (ctl_i.finish && hit &&
                 ((mode_q == MODE_INSERT) || (mode_q == MODE_DELETE))) begin
      mem_we    = 1'b1;
      mem_wdata = (mode_q == MODE_INSERT) ? key_q : '0;
    end
  end

  dht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (pos_q),
    .rdata_o (rd_data)
  );

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/dht_ctrl.sv =====
// Controller state machine: clear pass, hashing, step reduction, probing and completion.
`default_nettype none

module dht_ctrl
  import dht_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  output logic          done_o,
  output dht_ctl_t      ctl_o,
  input  wire dht_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_HASH,
    S_REDUCE,
    S_PROBE
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.skip) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        ctl_o.hash_en = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        ctl_o.reduce_en = 1'b1;
        if (sts_i.reduce_last) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        ctl_o.probe_en = 1'b1;
        if (sts_i.probe_hit || sts_i.probe_miss) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ctl_o.finish;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dht_checker.sv =====
// Port-level checker for the double hashing table unit, with its bind.
`default_nettype none

module dht_port_checker
  import dht_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire dht_cmd_t    cmd_i,
  input wire logic        done_o,
  input wire dht_result_t result_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low after an input transfer");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != ST_OK)) |-> (result_o.slot_index == '0))
    else $error("nonzero slot index on a failed operation");

  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.key == '0)) |=> ##1
      (done_o && (result_o.status == ST_ZERO_KEY)))
    else $error("zero key not rejected in two cycles");

endmodule

bind double_hash_table_unit dht_port_checker u_dht_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

// ===== verif/dht_checker.sv =====
// Scoreboard for the double hashing table unit: shadow table, expected results and compares.
module dht_checker
  import dht_pkg::*;
#(
  parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = STEP_MODULUS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire dht_cmd_t    cmd_i,
  input  wire logic        done_i,
  input  wire dht_result_t result_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               checked_o,
  output int               ok_seen_o,
  output int               full_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0] slot_copy [TABLE_SIZE];
  dht_result_t      expected_results [$];
  int               mismatch_count = 0;
  int               checked_count  = 0;
  int               ok_count       = 0;
  int               full_count     = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] dht mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic dht_result_t apply_command(dht_cmd_t c);
    dht_result_t      r;
    logic [KEY_W-1:0] target;
    int unsigned      key_u;
    int unsigned      pos;
    int unsigned      stride;
    int unsigned      hit;
    bit               found;
    r.status     = ST_NOT_FOUND;
    r.slot_index = '0;
    found        = 1'b0;
    hit          = 0;
    key_u        = c.key;
    if (c.key == '0) begin
      r.status = ST_ZERO_KEY;
    end else if (c.mode == MODE_INSERT || c.mode == MODE_SEARCH || c.mode == MODE_DELETE) begin
      target = (c.mode == MODE_INSERT) ? '0 : c.key;
      pos    = key_u % TABLE_SIZE;
      stride = STEP_MODULUS - key_u % STEP_MODULUS;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (!found && slot_copy[pos] == target) begin
          found = 1'b1;
          hit   = pos;
        end
        pos = (pos + stride) % TABLE_SIZE;
      end
      if (found) begin
        r.status     = ST_OK;
        r.slot_index = SLOT_OUT_W'(hit);
        if (c.mode == MODE_INSERT) slot_copy[hit] = c.key;
        else if (c.mode == MODE_DELETE) slot_copy[hit] = '0;
      end else if (c.mode == MODE_INSERT) begin
        r.status = ST_FULL;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dht_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_SIZE; s++) slot_copy[s] = '0;
      expected_results.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
      ok_seen_o    <= 0;
      full_seen_o  <= 0;
    end else begin
      if (done_i) begin
        checked_count++;
        if (result_i.status == ST_OK) ok_count++;
        if (result_i.status == ST_FULL) full_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d slot %0d with nothing outstanding",
                                    result_i.status, result_i.slot_index));
        end else begin
          want = expected_results.pop_front();
          if (result_i.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      result_i.status, want.status));
          if (result_i.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index got %0d expected %0d",
                                      result_i.slot_index, want.slot_index));
        end
      end
      if (start_i && !busy_i) expected_results.push_back(apply_command(cmd_i));
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_count;
      checked_o    <= checked_count;
      ok_seen_o    <= ok_count;
      full_seen_o  <= full_count;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the double hashing table unit: clock, reset, command stimulus and verdict.
module tb_top;
  import dht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_N      = 20;
  localparam int PHASE_ITEMS = 476;
  localparam int IDLE_LIMIT  = 3000;
  localparam int FAMILY      = 112;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  dht_cmd_t    cmd    = '0;
  logic        done;
  dht_result_t result;

  int mismatches;
  int pending;
  int checked;
  int ok_seen;
  int full_seen;
  int idle_cycles = 0;
  int mode_count [4] = '{default: 0};
  int zero_count = 0;

  logic [KEY_W-1:0] key_pool [POOL_N];
  int unsigned      family_base [4];

  double_hash_table_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd),
    .done_o   (done),
    .result_o (result)
  );

  dht_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .result_i     (result),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .ok_seen_o    (ok_seen),
    .full_seen_o  (full_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic issue(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                       input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= {m, k};
    do @(posedge clk_i); while (busy);
    if (k == '0) zero_count++;
    else mode_count[m]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    int unsigned roll;
    int unsigned base;
    roll = $urandom_range(9);
    base = family_base[$urandom_range(3)];
    if (roll < 5) return KEY_W'(base + FAMILY * $urandom_range(8));
    if (roll < 8) return KEY_W'(base + FAMILY * $urandom_range(19173960));
    return KEY_W'($urandom_range(32'h7FFF_FFFF, 1));
  endfunction

  task automatic random_phase(input int items, input int idle_pct, input int ins_pct);
    int unsigned      roll;
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(15) == 0) key_pool[$urandom_range(POOL_N-1)] = fresh_key();
      k    = key_pool[$urandom_range(POOL_N-1)];
      roll = $urandom_range(99);
      if (roll < ins_pct) m = MODE_INSERT;
      else if (roll < ins_pct + 28) m = MODE_SEARCH;
      else if (roll < 94) m = MODE_DELETE;
      else if (roll < 97) m = MODE_UNUSED;
      else begin
        m = MODE_W'($urandom_range(3));
        k = '0;
      end
      if ($urandom_range(19) == 0) k = KEY_W'($urandom());
      issue(m, k, idle_pct);
    end
  endtask

  initial begin : stimulus
    family_base[0] = 5;
    family_base[1] = 3;
    family_base[2] = 1;
    family_base[3] = $urandom_range(FAMILY - 1, 1);
    for (int p = 0; p < POOL_N; p++) key_pool[p] = fresh_key();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(MODE_INSERT, '0, 0);
    issue(MODE_SEARCH, '0, 0);
    issue(MODE_DELETE, '0, 0);
    issue(MODE_UNUSED, '0, 0);
    issue(MODE_UNUSED, '1, 0);
    issue(MODE_SEARCH, '1, 0);
    issue(MODE_INSERT, '1, 0);
    issue(MODE_SEARCH, '1, 0);
    issue(MODE_DELETE, '1, 0);
    issue(MODE_DELETE, '1, 0);
    // step 2 covers only half the table: the ninth key finds its sequence full
    for (int n = 0; n < 9; n++) issue(MODE_INSERT, KEY_W'(5 + FAMILY * n), 0);
    issue(MODE_SEARCH, KEY_W'(5 + FAMILY * 8), 0);
    issue(MODE_DELETE, KEY_W'(5 + FAMILY * 3), 0);
    issue(MODE_INSERT, KEY_W'(5 + FAMILY * 8), 0);
    drain();

    random_phase(PHASE_ITEMS, 0, 45);
    drain();
    random_phase(PHASE_ITEMS, 65, 30);
    drain();
    random_phase(PHASE_ITEMS, 36, 38);
    drain();

    repeat (64) @(posedge clk_i);
    $display("covered %0d inserts, %0d searches, %0d deletes, %0d unused-mode, %0d zero-key",
             mode_count[MODE_INSERT], mode_count[MODE_SEARCH], mode_count[MODE_DELETE],
             mode_count[MODE_UNUSED], zero_count);
    $display("checked %0d results: %0d hits or writes, %0d table-full, %0d mismatches",
             checked, ok_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
